// ===== src/sha1_hash_engine_macros.svh =====
// Assertion macros for the SHA-1 hash engine.
// Included by the top level; no other dependencies.
`ifndef SHA1_HASH_ENGINE_MACROS_SVH
`define SHA1_HASH_ENGINE_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, checked outside reset
`define SHA1_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sha1 engine assertion failed");
// Next-cycle implication, checked outside reset
`define SHA1_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sha1 engine assertion failed");
`else
`define SHA1_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define SHA1_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== src/sha1_pkg.sv =====
// Shared types, constants and round functions of the SHA-1 hash engine.
// No dependencies.
package sha1_pkg;

   // Input word: one message byte with flags
   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       end_of_message;
   } req_type;

   // Result word: one digest word
   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   // Head of the item queue, front to back
   typedef struct packed {
      logic    valid;
      req_type item;
   } queue_out_type;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   localparam int         DIGEST_WORDS = 5;
   localparam logic [2:0] LAST_INDEX   = 3'd4;
   localparam logic [6:0] LAST_ROUND   = 7'd79;
   localparam logic [6:0] SCHED_ROUNDS = 7'd16;
   localparam logic [5:0] LAST_SLOT    = 6'd63;
   localparam logic [5:0] LENGTH_SLOT  = 6'd56;
   localparam logic [7:0] PAD_BYTE     = 8'h80;

   localparam logic [31:0] INIT_H0 = 32'h67452301;
   localparam logic [31:0] INIT_H1 = 32'hEFCDAB89;
   localparam logic [31:0] INIT_H2 = 32'h98BADCFE;
   localparam logic [31:0] INIT_H3 = 32'h10325476;
   localparam logic [31:0] INIT_H4 = 32'hC3D2E1F0;

   localparam logic [31:0] K_CH  = 32'h5A827999;
   localparam logic [31:0] K_P1  = 32'h6ED9EBA1;
   localparam logic [31:0] K_MAJ = 32'h8F1BBCDC;
   localparam logic [31:0] K_P2  = 32'hCA62C1D6;

   // Initial chaining value, word by word
   function automatic logic [31:0] init_h(input logic [2:0] i);
      logic [31:0] h;
      case (i)
         3'd0:    h = INIT_H0;
         3'd1:    h = INIT_H1;
         3'd2:    h = INIT_H2;
         3'd3:    h = INIT_H3;
         default: h = INIT_H4;
      endcase
      return h;
   endfunction

   // Round function by round number
   function automatic logic [31:0] round_f(input logic [6:0] t, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
      logic [31:0] f;
      case (t) inside
         [7'd0:7'd19]:  f = (b & c) | (~b & d);
         [7'd40:7'd59]: f = (b & c) | (b & d) | (c & d);
         default:       f = b ^ c ^ d;
      endcase
      return f;
   endfunction

   // Round constant by round number
   function automatic logic [31:0] round_k(input logic [6:0] t);
      logic [31:0] k;
      case (t) inside
         [7'd0:7'd19]:  k = K_CH;
         [7'd20:7'd39]: k = K_P1;
         [7'd40:7'd59]: k = K_MAJ;
         default:       k = K_P2;
      endcase
      return k;
   endfunction

endpackage

// ===== src/sha1_front.sv =====
// Front end of the SHA-1 hash engine: takes input words, drops empty ones,
// and queues the rest for the back end. Depends on sha1_pkg.
module sha1_front import sha1_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  req_type       req_word,
   output queue_out_type q_head,
   input  logic          q_pop
);

   req_type               entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ff, wr_in;
   logic [QUEUE_AW-1:0]   rd_ff, rd_in;
   logic [QUEUE_CW-1:0]   cnt_ff, cnt_in;
   logic                  keep;
   logic                  push;

   // Stall only when the queue is full
   assign req_stall = (cnt_ff == QUEUE_CW'(QUEUE_DEPTH));

   // Drop words that carry neither a byte nor an end mark
   assign keep = req_word.byte_present | req_word.end_of_message;
   assign push = req_valid & ~req_stall & keep;

   assign q_head.valid = (cnt_ff != '0);
   assign q_head.item  = entry_ff[rd_ff];

   // Advance pointers and count
   always_comb begin
      wr_in  = push  ? wr_ff + QUEUE_AW'(1) : wr_ff;
      rd_in  = q_pop ? rd_ff + QUEUE_AW'(1) : rd_ff;
      cnt_in = cnt_ff + QUEUE_CW'(push) - QUEUE_CW'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Store the incoming word
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= req_word;
      end
   end

endmodule

// ===== src/sha1_back.sv =====
// Back end of the SHA-1 hash engine: packs bytes, pads, runs the rounds
// one per cycle and shifts out the digest. Depends on sha1_pkg.
module sha1_back import sha1_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  queue_out_type q_head,
   output logic          q_pop,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_type       rsp_word
);

   typedef enum logic [4:0] {
      ST_FETCH = 5'b00001,
      ST_PAD   = 5'b00010,
      ST_COMP  = 5'b00100,
      ST_ADD   = 5'b01000,
      ST_OUT   = 5'b10000
   } state_type;

   state_type   state_ff, state_in;
   logic [5:0]  pos_ff, pos_in;
   logic [23:0] acc_ff, acc_in;
   logic [31:0] win_ff [16];
   logic [31:0] win_in [16];
   logic [31:0] reg_ff [5];
   logic [31:0] reg_in [5];
   logic [31:0] chain_ff [DIGEST_WORDS];
   logic [31:0] chain_in [DIGEST_WORDS];
   logic [63:0] bits_ff, bits_in;
   logic [6:0]  round_ff, round_in;
   logic [2:0]  idx_ff, idx_in;
   logic        mark_ff, mark_in;
   logic        len_ff, len_in;
   logic        pad_ff, pad_in;
   logic        fin_ff, fin_in;

   logic        put_en;
   logic [7:0]  put_byte;
   logic        len_sel;
   logic [7:0]  len_byte;
   logic [31:0] sched_w;
   logic [31:0] wt;
   logic [31:0] tmp;

   // Result port straight from registers
   assign rsp_valid            = (state_ff == ST_OUT);
   assign rsp_word.digest_word = chain_ff[0];
   assign rsp_word.word_index  = idx_ff;
   assign rsp_word.last_word   = (idx_ff == LAST_INDEX);

   // Padding byte choice: mark, zeros, then big-endian length
   assign len_sel  = mark_ff & (len_ff | (pos_ff == LENGTH_SLOT));
   assign len_byte = bits_ff[{~pos_ff[2:0], 3'b000} +: 8];

   // Message schedule and round sum
   assign sched_w = win_ff[13] ^ win_ff[8] ^ win_ff[2] ^ win_ff[0];
   assign wt      = (round_ff < SCHED_ROUNDS) ? win_ff[0] : {sched_w[30:0], sched_w[31]};
   assign tmp     = {reg_ff[0][26:0], reg_ff[0][31:27]}
                  + round_f(round_ff, reg_ff[1], reg_ff[2], reg_ff[3])
                  + reg_ff[4] + round_k(round_ff) + wt;

   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      acc_in   = acc_ff;
      win_in   = win_ff;
      reg_in   = reg_ff;
      chain_in = chain_ff;
      bits_in  = bits_ff;
      round_in = round_ff;
      idx_in   = idx_ff;
      mark_in  = mark_ff;
      len_in   = len_ff;
      pad_in   = pad_ff;
      fin_in   = fin_ff;
      q_pop    = 1'b0;
      put_en   = 1'b0;
      put_byte = q_head.item.data_byte;

      case (state_ff)
         ST_FETCH: begin
            if (q_head.valid) begin
               q_pop = 1'b1;
               if (q_head.item.byte_present) begin
                  put_en  = 1'b1;
                  bits_in = bits_ff + 64'd8;
               end
               if (q_head.item.end_of_message) begin
                  pad_in = 1'b1;
               end
               if (q_head.item.byte_present && (pos_ff == LAST_SLOT)) begin
                  state_in = ST_COMP;
               end else if (q_head.item.end_of_message) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            put_en   = 1'b1;
            put_byte = !mark_ff ? PAD_BYTE : (len_sel ? len_byte : 8'h00);
            mark_in  = 1'b1;
            len_in   = len_sel;
            if (pos_ff == LAST_SLOT) begin
               state_in = ST_COMP;
               fin_in   = len_sel;
            end
         end
         ST_COMP: begin
            // One round: rotate working registers, slide the schedule window
            reg_in[0] = tmp;
            reg_in[1] = reg_ff[0];
            reg_in[2] = {reg_ff[1][1:0], reg_ff[1][31:2]};
            reg_in[3] = reg_ff[2];
            reg_in[4] = reg_ff[3];
            for (int i = 0; i < 15; i++) begin
               win_in[i] = win_ff[i+1];
            end
            win_in[15] = wt;
            round_in   = round_ff + 7'd1;
            if (round_ff == LAST_ROUND) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            for (int i = 0; i < DIGEST_WORDS; i++) begin
               chain_in[i] = chain_ff[i] + reg_ff[i];
            end
            idx_in = '0;
            if (fin_ff) begin
               state_in = ST_OUT;
            end else if (pad_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_FETCH;
            end
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               for (int i = 0; i < DIGEST_WORDS - 1; i++) begin
                  chain_in[i] = chain_ff[i+1];
               end
               chain_in[DIGEST_WORDS-1] = chain_ff[0];
               idx_in = idx_ff + 3'd1;
               if (idx_ff == LAST_INDEX) begin
                  // Message done: restore the chaining value and counters
                  for (int i = 0; i < DIGEST_WORDS; i++) begin
                     chain_in[i] = init_h(3'(i));
                  end
                  bits_in  = '0;
                  pos_in   = '0;
                  mark_in  = 1'b0;
                  len_in   = 1'b0;
                  pad_in   = 1'b0;
                  fin_in   = 1'b0;
                  idx_in   = '0;
                  state_in = ST_FETCH;
               end
            end
         end
         default: begin
            state_in = ST_FETCH;
         end
      endcase

      // Pack one byte; push each finished word into the window
      if (put_en) begin
         acc_in = {acc_ff[15:0], put_byte};
         pos_in = pos_ff + 6'd1;
         if (pos_ff[1:0] == 2'b11) begin
            for (int i = 0; i < 15; i++) begin
               win_in[i] = win_ff[i+1];
            end
            win_in[15] = {acc_ff, put_byte};
         end
      end

      // Load working registers when a block is complete
      if ((state_in == ST_COMP) && (state_ff != ST_COMP)) begin
         reg_in   = chain_ff;
         round_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_FETCH;
         pos_ff   <= '0;
         bits_ff  <= '0;
         round_ff <= '0;
         idx_ff   <= '0;
         mark_ff  <= 1'b0;
         len_ff   <= 1'b0;
         pad_ff   <= 1'b0;
         fin_ff   <= 1'b0;
         for (int i = 0; i < DIGEST_WORDS; i++) begin
            chain_ff[i] <= init_h(3'(i));
         end
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         bits_ff  <= bits_in;
         round_ff <= round_in;
         idx_ff   <= idx_in;
         mark_ff  <= mark_in;
         len_ff   <= len_in;
         pad_ff   <= pad_in;
         fin_ff   <= fin_in;
         chain_ff <= chain_in;
      end
   end

   // Hold the datapath words
   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      win_ff <= win_in;
      reg_ff <= reg_in;
   end

endmodule

// ===== src/sha1_hash_engine.sv =====
// Channel   Ports                         Word
// input     req_valid/req_stall/req_word  req_type: data_byte, byte_present, end_of_message
// result    rsp_valid/rsp_stall/rsp_word  rsp_type: digest_word, word_index, last_word
//
// The back end packs queued bytes one at a time; each full 64-byte block then runs
// 80 rounds on one round unit, followed by the chaining add. An end word adds the
// padding bytes, one per cycle, one or two more blocks, and five result words.
// Synchronous reset clears control state and loads the initial chaining value.
// A four-word queue keeps taking input until full while the back end computes or waits
// on rsp_stall; a stalled digest word holds in its register.
// Top level of the SHA-1 hash engine. Depends on sha1_pkg, sha1_front,
// sha1_back and sha1_hash_engine_macros.svh.
`include "sha1_hash_engine_macros.svh"
module sha1_hash_engine import sha1_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_word,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_word
);

   queue_out_type q_head;
   logic          q_pop;

   // Accept and queue input words
   sha1_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .q_head    (q_head),
      .q_pop     (q_pop)
   );

   // Compress blocks and deliver the digest
   sha1_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   `SHA1_ASSERT_IMP(a_pop_nonempty, clock, reset, q_pop, q_head.valid)
   `SHA1_ASSERT_NXT(a_idx_step, clock, reset, rsp_valid && !rsp_stall && !rsp_word.last_word, rsp_valid && (rsp_word.word_index == $past(rsp_word.word_index) + 3'd1))
   `SHA1_ASSERT_NXT(a_digest_end, clock, reset, rsp_valid && !rsp_stall && rsp_word.last_word, !rsp_valid)

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the byte-serial SHA-1 hash engine: a directed table
// then random messages, checked by an in-bench SHA-1 predictor or typed digest.
// Depends on sha1_pkg and sha1_hash_engine.
module tb import sha1_pkg::*; ;

   localparam logic [159:0] EMPTY_DIGEST = 160'hda39a3ee_5e6b4b0d_3255bfef_95601890_afd80709;
   localparam logic [159:0] ABC_DIGEST   = 160'ha9993e36_4706816a_ba3e2571_7850c26c_9cd0d89d;
   localparam int TARGET_ITEMS = 270;
   localparam int DRAIN_CYCLES = 400;
   localparam int NUM_ROWS     = 17;

   // One directed row: the word to send, and a typed digest where one is known
   typedef struct packed {
      logic [7:0]   data_byte;
      logic         byte_present;
      logic         end_of_message;
      logic         known;
      logic [159:0] digest;
   } stim_row_type;

   localparam stim_row_type STIM_TABLE [NUM_ROWS] = '{
      '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},  // empty message
      '{8'h61, 1'b1, 1'b0, 1'b0, 160'h0},
      '{8'h62, 1'b1, 1'b0, 1'b0, 160'h0},
      '{8'h00, 1'b0, 1'b0, 1'b0, 160'h0},        // empty word inside a message
      '{8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST},    // "abc", end on the last byte
      '{8'hff, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},  // data ignored when not present
      '{8'hab, 1'b0, 1'b0, 1'b0, 160'h0},
      '{8'hff, 1'b1, 1'b0, 1'b0, 160'h0},
      '{8'h00, 1'b1, 1'b0, 1'b0, 160'h0},
      '{8'h80, 1'b1, 1'b0, 1'b0, 160'h0},
      '{8'h7f, 1'b1, 1'b1, 1'b0, 160'h0},
      '{8'h00, 1'b1, 1'b1, 1'b0, 160'h0},        // single zero byte
      '{8'hff, 1'b1, 1'b1, 1'b0, 160'h0},        // single all-ones byte
      '{8'h5a, 1'b1, 1'b0, 1'b0, 160'h0},
      '{8'ha5, 1'b1, 1'b0, 1'b0, 160'h0},
      '{8'h00, 1'b0, 1'b1, 1'b0, 160'h0},        // empty end word after bytes
      '{8'hc3, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST}
   };

   localparam int EDGE_LENGTHS [8] = '{55, 56, 57, 63, 64, 65, 119, 120};

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_word = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_word;

   // Predictor state
   logic [31:0] msg_block [16];
   logic [31:0] chain [5];
   logic [63:0] msg_bits;
   int          fill_pos;

   rsp_type pending_words [$];
   rsp_type want;
   int      error_count = 0;
   int      words_checked = 0;
   int      hashed_items = 0;
   int      ignored_items = 0;
   int      messages_done = 0;
   int      stall_left = 3;
   bit      send_burst = 1'b0;
   bit      rsp_burst = 1'b0;

   sha1_hash_engine i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always #5 clock = ~clock;

   initial begin
      #3_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   task automatic report(input string what);
      error_count++;
      $display("MISMATCH at %0t: %s", $time, what);
   endtask

   function automatic logic [31:0] rol(input logic [31:0] x, input int n);
      return (x << n) | (x >> (32 - n));
   endfunction

   // Run the 80 rounds on the buffered block and fold into the chaining value
   task automatic compress_block();
      logic [31:0] w [16];
      logic [31:0] a, b, c, d, e, f, k, tmp;
      for (int i = 0; i < 16; i++) w[i] = msg_block[i];
      a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
      for (int t = 0; t < 80; t++) begin
         if (t >= 16) begin
            w[t % 16] = rol(w[(t + 13) % 16] ^ w[(t + 8) % 16] ^
                            w[(t + 2) % 16] ^ w[t % 16], 1);
         end
         if (t < 20) begin
            f = (b & c) | (~b & d);
            k = K_CH;
         end else if (t < 40) begin
            f = b ^ c ^ d;
            k = K_P1;
         end else if (t < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = K_MAJ;
         end else begin
            f = b ^ c ^ d;
            k = K_P2;
         end
         tmp = rol(a, 5) + f + e + k + w[t % 16];
         e = d; d = c; c = rol(b, 30); b = a; a = tmp;
      end
      chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
   endtask

   // Place one byte big-endian in the block; compress once it is full
   task automatic absorb(input logic [7:0] b);
      int shift;
      shift = (3 - fill_pos % 4) * 8;
      if (fill_pos % 4 == 0) begin
         msg_block[fill_pos / 4] = 32'(b) << shift;
      end else begin
         msg_block[fill_pos / 4] |= 32'(b) << shift;
      end
      fill_pos++;
      if (fill_pos == 64) begin
         compress_block();
         fill_pos = 0;
      end
   endtask

   task automatic restart_hash();
      chain[0] = INIT_H0; chain[1] = INIT_H1; chain[2] = INIT_H2;
      chain[3] = INIT_H3; chain[4] = INIT_H4;
      msg_bits = '0;
      fill_pos = 0;
   endtask

   // Advance the hash by one accepted word; on an end word pad and return the digest
   task automatic hash_item(input req_type w, output bit done, output logic [159:0] digest);
      logic [63:0] len;
      done = 1'b0;
      digest = '0;
      if (w.byte_present) begin
         absorb(w.data_byte);
         msg_bits += 64'd8;
      end
      if (w.end_of_message) begin
         len = msg_bits;
         absorb(PAD_BYTE);
         while (fill_pos != int'(LENGTH_SLOT)) absorb(8'h00);
         for (int i = 7; i >= 0; i--) absorb(len[i * 8 +: 8]);
         digest = {chain[0], chain[1], chain[2], chain[3], chain[4]};
         done = 1'b1;
         restart_hash();
      end
   endtask

   // Drive one word after a random gap, wait for it to be taken, then predict
   task automatic send_word(input req_type w, input bit use_typed, input logic [159:0] typed);
      int gap;
      bit done;
      logic [159:0] digest;
      rsp_type r;
      gap = send_burst ? 0 : $urandom_range(0, 19);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (w.byte_present || w.end_of_message) hashed_items++;
      else ignored_items++;
      hash_item(w, done, digest);
      if (done) begin
         if (use_typed) digest = typed;
         messages_done++;
         for (int i = 0; i < DIGEST_WORDS; i++) begin
            r.digest_word = digest[159 - 32 * i -: 32];
            r.word_index  = 3'(i);
            r.last_word   = (3'(i) == LAST_INDEX);
            pending_words.push_back(r);
         end
      end
   endtask

   // Drop valid and hold off until every expected digest word has come back
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_words.size() != 0) @(negedge clock);
   endtask

   // Send one random message of len bytes, with some empty words mixed in
   task automatic send_message(input int len);
      bit end_on_byte;
      req_type w;
      end_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 7) == 0) begin
            w.data_byte = 8'($urandom);
            w.byte_present = 1'b0;
            w.end_of_message = 1'b0;
            send_word(w, 1'b0, '0);
         end
         w.data_byte = 8'($urandom);
         w.byte_present = 1'b1;
         w.end_of_message = end_on_byte && (i == len - 1);
         send_word(w, 1'b0, '0);
      end
      if (!end_on_byte) begin
         w.data_byte = 8'($urandom);
         w.byte_present = 1'b0;
         w.end_of_message = 1'b1;
         send_word(w, 1'b0, '0);
      end
   endtask

   // Hold rsp_stall for the drawn number of cycles that a digest word waits
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         if (rsp_valid) stall_left = stall_left - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Check each accepted digest word against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         words_checked++;
         if (pending_words.size() == 0) begin
            report($sformatf("unexpected digest word %h index %0d",
                             rsp_word.digest_word, rsp_word.word_index));
         end else begin
            want = pending_words.pop_front();
            if (rsp_word.digest_word !== want.digest_word)
               report($sformatf("digest_word %h, expected %h (index %0d)",
                                rsp_word.digest_word, want.digest_word, want.word_index));
            if (rsp_word.word_index !== want.word_index)
               report($sformatf("word_index %0d, expected %0d",
                                rsp_word.word_index, want.word_index));
            if (rsp_word.last_word !== want.last_word)
               report($sformatf("last_word %b, expected %b (index %0d)",
                                rsp_word.last_word, want.last_word, want.word_index));
         end
         if (rsp_word.last_word) rsp_burst = ($urandom_range(0, 3) == 0);
         stall_left = rsp_burst ? 0 : $urandom_range(0, 19);
      end
   end

   initial begin
      int len;
      int pick;
      req_type w;
      restart_hash();
      for (int i = 0; i < 16; i++) msg_block[i] = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table
      foreach (STIM_TABLE[i]) begin
         w.data_byte      = STIM_TABLE[i].data_byte;
         w.byte_present   = STIM_TABLE[i].byte_present;
         w.end_of_message = STIM_TABLE[i].end_of_message;
         send_word(w, STIM_TABLE[i].known, STIM_TABLE[i].digest);
      end
      wait_idle();

      // Random messages, mostly short, some on the padding boundaries
      while (hashed_items + ignored_items < TARGET_ITEMS) begin
         send_burst = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 5) == 0) wait_idle();
         pick = $urandom_range(0, 9);
         if (pick < 6) len = $urandom_range(0, 20);
         else if (pick < 9) len = EDGE_LENGTHS[$urandom_range(0, 7)];
         else len = $urandom_range(0, 130);
         // Keep the last message within the item budget
         if (len > TARGET_ITEMS - hashed_items - ignored_items)
            len = TARGET_ITEMS - hashed_items - ignored_items;
         send_message(len);
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("Covered %0d messages from %0d hashed words and %0d empty words,",
               messages_done, hashed_items, ignored_items);
      $display("with %0d digest words checked under random gaps and stalls.", words_checked);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
